// ===== src/frame_rotate_flip_core_macros.svh =====
// Assertion macros for the frame rotate/flip RTL.
`ifndef FRAME_ROTATE_FLIP_CORE_MACROS_SVH
`define FRAME_ROTATE_FLIP_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FRF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define FRF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/frf_pkg.sv =====
// Shared constants and types of the frame rotate/flip core.
`default_nettype none

package frf_pkg;

   localparam int MAX_DIM_DEF    = 128;
   localparam int PIXEL_BITS_DEF = 32;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;
   localparam int SIZE_W     = 8;
   localparam int SIZE_RESET = 128;

   localparam logic [CSR_IDX_W-1:0] CSR_ROTATION   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIRROR_LR  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIRROR_UD  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_ROWS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COLS = 3'd4;

   localparam logic OP_PUSH  = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam logic [1:0] ROT_0   = 2'd0;
   localparam logic [1:0] ROT_90  = 2'd1;
   localparam logic [1:0] ROT_180 = 2'd2;
   localparam logic [1:0] ROT_270 = 2'd3;

   typedef struct packed {
      logic emit;
      logic store;
   } frf_cmd_type;

   typedef struct packed {
      logic frame_done;
      logic out_last;
   } frf_stat_type;

endpackage

`default_nettype wire

// ===== src/frf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module frf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== src/frf_ctrl.sv =====
// Controller: accept logic and frame-pending state machine.
`default_nettype none
`include "frame_rotate_flip_core_macros.svh"

module frf_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic                 op,
   output logic                      busy,
   output frf_pkg::frf_cmd_type      cmd_o,
   input  wire frf_pkg::frf_stat_type stat_i
);

   import frf_pkg::*;

   typedef enum logic [2:0] {
      ST_INIT    = 3'b001,
      ST_EMPTY   = 3'b010,
      ST_PENDING = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign busy   = (state_ff == ST_INIT);
   assign accept = start && !busy;

   assign cmd_o.emit  = accept && (state_ff == ST_PENDING);
   assign cmd_o.store = accept && (op == OP_PUSH);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            state_in = ST_EMPTY;
         end
         ST_EMPTY: begin
            if (cmd_o.store && stat_i.frame_done) begin
               state_in = ST_PENDING;
            end
         end
         ST_PENDING: begin
            if (cmd_o.store && stat_i.frame_done) begin
               state_in = ST_PENDING;
            end else if (cmd_o.emit && stat_i.out_last) begin
               state_in = ST_EMPTY;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   `FRF_ASSERT_NEXT(a_done_pends, cmd_o.store && stat_i.frame_done, state_ff == ST_PENDING, "completed frame not pending")
   `FRF_ASSERT_NEXT(a_last_empties, cmd_o.emit && stat_i.out_last && !(cmd_o.store && stat_i.frame_done), state_ff == ST_EMPTY, "readout end missed")
   `FRF_ASSERT_NEXT(a_init_once, state_ff != ST_INIT, state_ff != ST_INIT, "init state reentered")

endmodule

`default_nettype wire

// ===== src/frf_datapath.sv =====
// Datapath: CSRs, ping-pong frame store, write/read counters, address map.
`default_nettype none

module frf_datapath #(
   parameter int MAX_DIM    = frf_pkg::MAX_DIM_DEF,
   parameter int PIXEL_BITS = frf_pkg::PIXEL_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire frf_pkg::frf_cmd_type            cmd_i,
   output frf_pkg::frf_stat_type                stat_o,
   input  wire logic [PIXEL_BITS-1:0]           pixel_in,
   input  wire logic                            csr_we,
   input  wire logic [frf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [frf_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output logic                                 rsp_valid,
   output logic      [PIXEL_BITS-1:0]           rsp_pixel_out,
   output logic                                 rsp_frame_last
);

   import frf_pkg::*;

   localparam int BANK    = MAX_DIM * MAX_DIM;
   localparam int IDX_W   = $clog2(BANK);
   localparam int ADDR_W  = $clog2(2 * BANK);
   localparam int COORD_W = $clog2(MAX_DIM);
   localparam int DIM_W   = $clog2(MAX_DIM + 1);
   localparam int TOT_W   = 2 * DIM_W;
   localparam int CMP_W   = TOT_W + 1;
   localparam int PROD_W  = COORD_W + DIM_W;
   localparam int RST_DIM = (SIZE_RESET > MAX_DIM) ? MAX_DIM : SIZE_RESET;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [SIZE_W-1:0] v);
      if (v == '0) begin
         return DIM_W'(1);
      end else if (int'(v) > MAX_DIM) begin
         return DIM_W'(MAX_DIM);
      end
      return DIM_W'(v);
   endfunction

   // live configuration
   logic [1:0]        rot_ff;
   logic              lr_ff;
   logic              ud_ff;
   logic [SIZE_W-1:0] rows_ff;
   logic [SIZE_W-1:0] cols_ff;

   // geometry latched for the pending frame
   logic [DIM_W-1:0]   lat_cols_ff, lat_cols_in;
   logic [COORD_W-1:0] lat_r1_ff, lat_r1_in;
   logic [COORD_W-1:0] lat_c1_ff, lat_c1_in;
   logic [COORD_W-1:0] lat_h1_ff, lat_h1_in;
   logic [COORD_W-1:0] lat_w1_ff, lat_w1_in;
   logic [1:0]         lat_rot_ff, lat_rot_in;
   logic               lat_lr_ff, lat_lr_in;
   logic               lat_ud_ff, lat_ud_in;

   logic               bank_ff, bank_in;
   logic [IDX_W-1:0]   wr_idx_ff, wr_idx_in;
   logic [COORD_W-1:0] out_i_ff, out_i_in;
   logic [COORD_W-1:0] out_j_ff, out_j_in;
   logic               valid_ff, valid_in;
   logic               last_ff, last_in;

   logic [DIM_W-1:0]   rows_c, cols_c;
   logic [TOT_W-1:0]   total;
   logic               frame_done, out_last, swap;
   logic [COORD_W-1:0] ii, jj, src_r, src_c;
   logic [PROD_W-1:0]  src_lin;
   logic [IDX_W-1:0]   src_idx;
   logic [ADDR_W-1:0]  waddr, raddr;

   assign rows_c     = clamp_dim(rows_ff);
   assign cols_c     = clamp_dim(cols_ff);
   assign total      = TOT_W'(rows_c) * TOT_W'(cols_c);
   assign frame_done = (CMP_W'(wr_idx_ff) + CMP_W'(1)) >= CMP_W'(total);
   assign out_last   = (out_i_ff == lat_h1_ff) && (out_j_ff == lat_w1_ff);
   assign swap       = cmd_i.store && frame_done;

   assign stat_o.frame_done = frame_done;
   assign stat_o.out_last   = out_last;

   // output raster position -> source pixel of the stored frame
   assign ii = lat_ud_ff ? (lat_h1_ff - out_i_ff) : out_i_ff;
   assign jj = lat_lr_ff ? (lat_w1_ff - out_j_ff) : out_j_ff;

   always_comb begin
      case (lat_rot_ff)
         ROT_0: begin
            src_r = ii;
            src_c = jj;
         end
         ROT_90: begin
            src_r = jj;
            src_c = lat_c1_ff - ii;
         end
         ROT_180: begin
            src_r = lat_r1_ff - ii;
            src_c = lat_c1_ff - jj;
         end
         default: begin
            src_r = lat_r1_ff - jj;
            src_c = ii;
         end
      endcase
   end

   assign src_lin = PROD_W'(src_r) * PROD_W'(lat_cols_ff) + PROD_W'(src_c);
   assign src_idx = IDX_W'(src_lin);

   assign waddr = bank_ff ? (ADDR_W'(BANK) + ADDR_W'(wr_idx_ff)) : ADDR_W'(wr_idx_ff);
   assign raddr = bank_ff ? ADDR_W'(src_idx) : (ADDR_W'(BANK) + ADDR_W'(src_idx));

   frf_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (2 * BANK)
   ) u_store (
      .clock (clock),
      .we    (cmd_i.store),
      .waddr (waddr),
      .wdata (pixel_in),
      .re    (cmd_i.emit),
      .raddr (raddr),
      .rdata (rsp_pixel_out)
   );

   always_comb begin
      bank_in     = bank_ff;
      wr_idx_in   = wr_idx_ff;
      out_i_in    = out_i_ff;
      out_j_in    = out_j_ff;
      lat_cols_in = lat_cols_ff;
      lat_r1_in   = lat_r1_ff;
      lat_c1_in   = lat_c1_ff;
      lat_h1_in   = lat_h1_ff;
      lat_w1_in   = lat_w1_ff;
      lat_rot_in  = lat_rot_ff;
      lat_lr_in   = lat_lr_ff;
      lat_ud_in   = lat_ud_ff;
      valid_in    = cmd_i.emit;
      last_in     = cmd_i.emit && out_last;

      if (cmd_i.emit) begin
         if (out_last) begin
            out_i_in = '0;
            out_j_in = '0;
         end else if (out_j_ff == lat_w1_ff) begin
            out_i_in = out_i_ff + COORD_W'(1);
            out_j_in = '0;
         end else begin
            out_j_in = out_j_ff + COORD_W'(1);
         end
      end

      if (cmd_i.store) begin
         if (frame_done) begin
            wr_idx_in = '0;
         end else begin
            wr_idx_in = wr_idx_ff + IDX_W'(1);
         end
      end

      // new frame complete: swap banks, restart readout, latch geometry
      if (swap) begin
         bank_in     = !bank_ff;
         out_i_in    = '0;
         out_j_in    = '0;
         lat_cols_in = cols_c;
         lat_r1_in   = COORD_W'(rows_c - DIM_W'(1));
         lat_c1_in   = COORD_W'(cols_c - DIM_W'(1));
         lat_h1_in   = rot_ff[0] ? COORD_W'(cols_c - DIM_W'(1))
                                 : COORD_W'(rows_c - DIM_W'(1));
         lat_w1_in   = rot_ff[0] ? COORD_W'(rows_c - DIM_W'(1))
                                 : COORD_W'(cols_c - DIM_W'(1));
         lat_rot_in  = rot_ff;
         lat_lr_in   = lr_ff;
         lat_ud_in   = ud_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff      <= ROT_0;
         lr_ff       <= 1'b0;
         ud_ff       <= 1'b0;
         rows_ff     <= SIZE_W'(SIZE_RESET);
         cols_ff     <= SIZE_W'(SIZE_RESET);
         bank_ff     <= 1'b0;
         wr_idx_ff   <= '0;
         out_i_ff    <= '0;
         out_j_ff    <= '0;
         lat_cols_ff <= DIM_W'(RST_DIM);
         lat_r1_ff   <= COORD_W'(RST_DIM - 1);
         lat_c1_ff   <= COORD_W'(RST_DIM - 1);
         lat_h1_ff   <= COORD_W'(RST_DIM - 1);
         lat_w1_ff   <= COORD_W'(RST_DIM - 1);
         lat_rot_ff  <= ROT_0;
         lat_lr_ff   <= 1'b0;
         lat_ud_ff   <= 1'b0;
         valid_ff    <= 1'b0;
         last_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_ROTATION:   rot_ff  <= csr_wdata[1:0];
               CSR_MIRROR_LR:  lr_ff   <= csr_wdata[0];
               CSR_MIRROR_UD:  ud_ff   <= csr_wdata[0];
               CSR_FRAME_ROWS: rows_ff <= csr_wdata[SIZE_W-1:0];
               CSR_FRAME_COLS: cols_ff <= csr_wdata[SIZE_W-1:0];
               default: begin
               end
            endcase
         end
         bank_ff     <= bank_in;
         wr_idx_ff   <= wr_idx_in;
         out_i_ff    <= out_i_in;
         out_j_ff    <= out_j_in;
         lat_cols_ff <= lat_cols_in;
         lat_r1_ff   <= lat_r1_in;
         lat_c1_ff   <= lat_c1_in;
         lat_h1_ff   <= lat_h1_in;
         lat_w1_ff   <= lat_w1_in;
         lat_rot_ff  <= lat_rot_in;
         lat_lr_ff   <= lat_lr_in;
         lat_ud_ff   <= lat_ud_in;
         valid_ff    <= valid_in;
         last_ff     <= last_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_frame_last = last_ff;

endmodule

`default_nettype wire

// ===== src/frame_rotate_flip_core.sv =====
// Top level of the frame rotate/flip core.
//
// Usage:
//  - Input items: start is taken when busy is low. req_op selects push (store
//    req_pixel_in, row-major) or drain (emit only). Frames go into one half of
//    a ping-pong store; when a frame is complete it becomes pending.
//  - Every accepted item while a frame is pending emits one pixel of it, in
//    output raster order, rotated by quarter turns then mirrored as latched
//    at frame completion. rsp_valid strobes for one cycle, in the cycle after
//    the item is accepted; rsp_frame_last marks the final pixel of a frame.
//  - Throughput: one item per clock while busy is low. The read path is one
//    address multiply into the frame store, whose read port is registered.
//  - CSRs (csr_we/csr_index/csr_wdata) write with no wait; the user is to
//    write them between frames, as the block itself does not enforce it.
//  - Reset (synchronous) clears counters, banks and pending state; busy is
//    high while the controller is in its init state. The store is not cleared.
//  - The receiver cannot stall: each result must be taken in its cycle.
`default_nettype none

module frame_rotate_flip_core #(
   parameter int MAX_DIM    = frf_pkg::MAX_DIM_DEF,
   parameter int PIXEL_BITS = frf_pkg::PIXEL_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic                            req_op,
   input  wire logic [PIXEL_BITS-1:0]           req_pixel_in,
   output logic                                 rsp_valid,
   output logic      [PIXEL_BITS-1:0]           rsp_pixel_out,
   output logic                                 rsp_frame_last,
   input  wire logic                            csr_we,
   input  wire logic [frf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [frf_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import frf_pkg::*;

   frf_cmd_type  cmd;
   frf_stat_type stat;

   frf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .op     (req_op),
      .busy   (busy),
      .cmd_o  (cmd),
      .stat_i (stat)
   );

   frf_datapath #(
      .MAX_DIM    (MAX_DIM),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd_i          (cmd),
      .stat_o         (stat),
      .pixel_in       (req_pixel_in),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

`default_nettype wire

// ===== test/frame_rotate_flip_core_tb.sv =====
// Self-checking testbench for the frame rotate/flip core: random frames, transforms and idles.
`timescale 1ns / 100ps

module frame_rotate_flip_core_tb;
   import frf_pkg::*;

   localparam int DIM            = MAX_DIM_DEF;
   localparam int BANK_WORDS     = DIM * DIM;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int ITEM_TARGET    = 700;

   typedef struct packed {
      logic        op;
      logic [31:0] pixel;
   } pixel_item_type;

   typedef struct packed {
      logic [31:0] pixel;
      logic        last;
   } out_pixel_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_op = OP_PUSH;
   logic [31:0]           req_pixel_in = '0;
   logic                  rsp_valid;
   logic [31:0]           rsp_pixel_out;
   logic                  rsp_frame_last;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_ROTATION;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   frame_rotate_flip_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_pixel_in   (req_pixel_in),
      .rsp_valid      (rsp_valid),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_frame_last (rsp_frame_last),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   pixel_item_type pending_items[$];
   out_pixel_type  expected_pixels[$];
   pixel_item_type next_item;
   out_pixel_type  want;
   int unsigned hold_off = 0;
   bit          sender_gaps = 1'b1;
   int unsigned item_count = 0;
   int unsigned errors = 0;
   int unsigned quiet_cycles = 0;

   // predictor state
   logic [31:0] frame_image [0:2*BANK_WORDS-1];
   logic        wr_bank;
   int unsigned wr_pos, rd_pos;
   logic        frame_ready;
   logic [1:0]  rot_reg;
   logic        lr_reg, ud_reg;
   logic [7:0]  rows_reg, cols_reg;
   int unsigned lat_rows, lat_cols;
   logic [1:0]  lat_rot;
   logic        lat_lr, lat_ud;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic int unsigned clamp_size(input logic [7:0] v);
      if (v == 0) return 1;
      if (v > DIM) return DIM;
      return 32'(v);
   endfunction

   // store offset of output pixel k of the pending frame
   function automatic int unsigned source_index(input int unsigned k);
      int unsigned h, w, i, j, r, c;
      h = lat_rot[0] ? lat_cols : lat_rows;
      w = lat_rot[0] ? lat_rows : lat_cols;
      i = k / w;
      j = k % w;
      if (lat_ud) i = h - 1 - i;
      if (lat_lr) j = w - 1 - j;
      case (lat_rot)
         ROT_0: begin
            r = i;
            c = j;
         end
         ROT_90: begin
            r = j;
            c = lat_cols - 1 - i;
         end
         ROT_180: begin
            r = lat_rows - 1 - i;
            c = lat_cols - 1 - j;
         end
         default: begin
            r = lat_rows - 1 - j;
            c = i;
         end
      endcase
      return r * lat_cols + c;
   endfunction

   task automatic rotate_item(input logic op, input logic [31:0] px);
      int unsigned total;
      out_pixel_type res;
      if (frame_ready) begin
         res.pixel = frame_image[(wr_bank ? 0 : BANK_WORDS) + source_index(rd_pos)];
         res.last  = (rd_pos + 1 >= lat_rows * lat_cols);
         expected_pixels.push_back(res);
         if (res.last) begin
            frame_ready = 1'b0;
            rd_pos = 0;
         end else begin
            rd_pos++;
         end
      end
      if (op == OP_PUSH) begin
         total = clamp_size(rows_reg) * clamp_size(cols_reg);
         frame_image[(wr_bank ? BANK_WORDS : 0) + wr_pos] = px;
         if (wr_pos + 1 >= total) begin
            wr_bank = ~wr_bank;
            wr_pos = 0;
            rd_pos = 0;
            frame_ready = 1'b1;
            lat_rows = clamp_size(rows_reg);
            lat_cols = clamp_size(cols_reg);
            lat_rot = rot_reg;
            lat_lr = lr_reg;
            lat_ud = ud_reg;
         end else begin
            wr_pos++;
         end
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         hold_off <= 0;
      end else if (!start || !busy) begin
         if (hold_off != 0 || pending_items.size() == 0) begin
            start <= 1'b0;
            if (hold_off != 0) hold_off <= hold_off - 1;
         end else begin
            next_item = pending_items.pop_front();
            start <= 1'b1;
            req_op <= next_item.op;
            req_pixel_in <= next_item.pixel;
            hold_off <= sender_gaps ? $urandom_range(0, 5) : 0;
         end
      end
   end

   // monitor and predictor
   always @(posedge clock) begin
      if (reset) begin
         wr_bank = 1'b0;
         wr_pos = 0;
         rd_pos = 0;
         frame_ready = 1'b0;
         rot_reg = ROT_0;
         lr_reg = 1'b0;
         ud_reg = 1'b0;
         rows_reg = 8'(SIZE_RESET);
         cols_reg = 8'(SIZE_RESET);
         lat_rows = SIZE_RESET;
         lat_cols = SIZE_RESET;
         lat_rot = ROT_0;
         lat_lr = 1'b0;
         lat_ud = 1'b0;
         expected_pixels.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ROTATION:   rot_reg = csr_wdata[1:0];
               CSR_MIRROR_LR:  lr_reg = csr_wdata[0];
               CSR_MIRROR_UD:  ud_reg = csr_wdata[0];
               CSR_FRAME_ROWS: rows_reg = csr_wdata;
               CSR_FRAME_COLS: cols_reg = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (expected_pixels.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected result: pixel %h last %b", rsp_pixel_out, rsp_frame_last);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_pixel_out !== want.pixel || rsp_frame_last !== want.last) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: pixel exp %h got %h, last exp %b got %b",
                              want.pixel, rsp_pixel_out, want.last, rsp_frame_last);
               end
            end
         end
         if (start && !busy) rotate_item(req_op, req_pixel_in);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout");
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
   endtask

   task automatic set_transform(input logic [1:0] rot, input logic lr, input logic ud,
                                input logic [7:0] rows, input logic [7:0] cols);
      write_reg(CSR_ROTATION, {6'd0, rot});
      write_reg(CSR_MIRROR_LR, {7'd0, lr});
      write_reg(CSR_MIRROR_UD, {7'd0, ud});
      write_reg(CSR_FRAME_ROWS, rows);
      write_reg(CSR_FRAME_COLS, cols);
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic queue_item(input logic op, input logic [31:0] px);
      pixel_item_type it;
      it.op = op;
      it.pixel = px;
      pending_items.push_back(it);
      item_count++;
   endtask

   task automatic queue_frames(input int unsigned pushes, input int unsigned drain_pct,
                               input int unsigned drains);
      for (int n = 0; n < pushes; n++) begin
         if ($urandom_range(0, 99) < drain_pct) queue_item(OP_DRAIN, $urandom);
         queue_item(OP_PUSH, $urandom);
      end
      repeat (drains) queue_item(OP_DRAIN, $urandom);
   endtask

   // block is idle once the driver has nothing left and every result is in
   task automatic wait_quiet();
      do @(negedge clock);
      while (pending_items.size() != 0 || start || expected_pixels.size() != 0);
      repeat (2) @(negedge clock);
   endtask

   function automatic logic [7:0] pick_size();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return 8'd0;
      if (roll == 1) return 8'($urandom_range(7, 16));
      return 8'($urandom_range(1, 6));
   endfunction

   initial begin
      logic [7:0]  rows_w, cols_w;
      int unsigned total, pushes;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: drain with nothing pending, extreme pixels, push-driven readout
      set_transform(ROT_0, 1'b0, 1'b0, 8'd2, 8'd3);
      queue_item(OP_DRAIN, 32'hFFFF_FFFF);
      queue_item(OP_PUSH, 32'h0000_0000);
      queue_item(OP_PUSH, 32'hFFFF_FFFF);
      queue_item(OP_PUSH, 32'hAAAA_AAAA);
      queue_item(OP_PUSH, 32'h5555_5555);
      queue_item(OP_PUSH, 32'h8000_0000);
      queue_item(OP_PUSH, 32'h0000_0001);
      queue_frames(6, 0, 7);
      wait_quiet();

      // size shrinks mid-frame
      set_transform(ROT_90, 1'b1, 1'b0, 8'd2, 8'd2);
      queue_frames(3, 0, 0);
      wait_quiet();
      set_transform(ROT_90, 1'b1, 1'b0, 8'd1, 8'd2);
      queue_frames(1, 0, 3);
      wait_quiet();

      // largest sizes; first frame is read out under a different live setting
      set_transform(ROT_270, 1'b0, 1'b1, 8'd255, 8'd1);
      queue_frames(DIM, 0, 0);
      wait_quiet();
      set_transform(ROT_180, 1'b1, 1'b1, 8'd1, 8'd128);
      queue_frames(DIM, 10, DIM + 2);
      wait_quiet();

      while (item_count < ITEM_TARGET) begin
         rows_w = pick_size();
         cols_w = pick_size();
         total = clamp_size(rows_w) * clamp_size(cols_w);
         pushes = $urandom_range(1, 3) * total;
         if ($urandom_range(0, 2) == 0) pushes += $urandom_range(0, total - 1);
         sender_gaps = ($urandom_range(0, 3) != 0);
         set_transform(2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom), rows_w, cols_w);
         queue_frames(pushes, $urandom_range(0, 40),
                      $urandom_range(0, 1) ? 0 : total + $urandom_range(0, 2));
         wait_quiet();
      end

      repeat (5) @(posedge clock);
      if (errors == 0 && expected_pixels.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/frf_pkg.sv
src/frf_ram.sv
src/frf_ctrl.sv
src/frf_datapath.sv
src/frame_rotate_flip_core.sv
test/frame_rotate_flip_core_tb.sv
